>>> sv/cfd_pkg.sv
// Shared types, constants and register codes for the command frame deframer.
`timescale 1ns / 1ps

package cfd_pkg;

    localparam int MAX_PAYLOAD_DEF = 128;

    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 2;
    localparam int SLOT_W     = 2;
    localparam int INDEX_W    = 7;
    localparam int CHECK_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [BYTE_W-1:0]  HEADER_RST = 8'h24;
    localparam logic [BYTE_W-1:0]  SLOT0_ID_RST = 8'h01;
    localparam logic [BYTE_W-1:0]  SLOT0_LEN_RST = 8'd45;
    localparam logic [BYTE_W-1:0]  SLOT1_ID_RST = 8'h02;
    localparam logic [BYTE_W-1:0]  SLOT1_LEN_RST = 8'd81;
    localparam logic [BYTE_W-1:0]  SLOT2_ID_RST = 8'h55;
    localparam logic [BYTE_W-1:0]  SLOT2_LEN_RST = 8'd0;
    localparam logic [CHECK_W-1:0] CHECK_RST = 16'h5555;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER    = 3'd0,
        REG_SLOT0_ID  = 3'd1,
        REG_SLOT0_LEN = 3'd2,
        REG_SLOT1_ID  = 3'd3,
        REG_SLOT1_LEN = 3'd4,
        REG_SLOT2_ID  = 3'd5,
        REG_SLOT2_LEN = 3'd6,
        REG_CHECK     = 3'd7
    } cfg_idx_t;

    typedef enum logic [KIND_W-1:0] {
        EV_PAYLOAD  = 2'd0,
        EV_ACCEPT   = 2'd1,
        EV_BADCHECK = 2'd2,
        EV_UNKNOWN  = 2'd3
    } event_kind_t;

    localparam logic [SLOT_W-1:0] SLOT_0 = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_1 = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_2 = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0]  header;
        logic [BYTE_W-1:0]  slot0_ident;
        logic [BYTE_W-1:0]  slot0_length;
        logic [BYTE_W-1:0]  slot1_ident;
        logic [BYTE_W-1:0]  slot1_length;
        logic [BYTE_W-1:0]  slot2_ident;
        logic [BYTE_W-1:0]  slot2_length;
        logic [CHECK_W-1:0] expected_check;
    } cfg_t;

    typedef struct packed {
        logic                vld;
        event_kind_t         kind;
        logic [SLOT_W-1:0]   slot;
        logic [INDEX_W-1:0]  idx;
        logic [BYTE_W-1:0]   data;
    } evt_t;

endpackage

>>> sv/cfd_cfg_regs.sv
// Configuration register file for the deframer.
`timescale 1ns / 1ps

module cfd_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [cfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cfd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output cfd_pkg::cfg_t                    cfg
);
    import cfd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_HEADER:    cfg_next.header         = cfg_data[BYTE_W-1:0];
                REG_SLOT0_ID:  cfg_next.slot0_ident    = cfg_data[BYTE_W-1:0];
                REG_SLOT0_LEN: cfg_next.slot0_length   = cfg_data[BYTE_W-1:0];
                REG_SLOT1_ID:  cfg_next.slot1_ident    = cfg_data[BYTE_W-1:0];
                REG_SLOT1_LEN: cfg_next.slot1_length   = cfg_data[BYTE_W-1:0];
                REG_SLOT2_ID:  cfg_next.slot2_ident    = cfg_data[BYTE_W-1:0];
                REG_SLOT2_LEN: cfg_next.slot2_length   = cfg_data[BYTE_W-1:0];
                REG_CHECK:     cfg_next.expected_check = cfg_data[CHECK_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header         <= HEADER_RST;
            cfg_reg.slot0_ident    <= SLOT0_ID_RST;
            cfg_reg.slot0_length   <= SLOT0_LEN_RST;
            cfg_reg.slot1_ident    <= SLOT1_ID_RST;
            cfg_reg.slot1_length   <= SLOT1_LEN_RST;
            cfg_reg.slot2_ident    <= SLOT2_ID_RST;
            cfg_reg.slot2_length   <= SLOT2_LEN_RST;
            cfg_reg.expected_check <= CHECK_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/cfd_parser.sv
// Frame parser: phase state machine and per-byte event decode.
`timescale 1ns / 1ps

module cfd_parser #(
    parameter int MAX_PAYLOAD = cfd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [cfd_pkg::BYTE_W-1:0]   byte_in,
    input  cfd_pkg::cfg_t                cfg,
    output cfd_pkg::evt_t                evt
);
    import cfd_pkg::*;

    localparam logic [BYTE_W-1:0] MaxLen = BYTE_W'(MAX_PAYLOAD);

    typedef enum logic [4:0] {
        PH_HUNT     = 5'b00001,
        PH_COMMAND  = 5'b00010,
        PH_PAYLOAD  = 5'b00100,
        PH_CHECK_HI = 5'b01000,
        PH_CHECK_LO = 5'b10000
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [BYTE_W-1:0]   count_reg, count_next;
    logic [BYTE_W-1:0]   check_hi_reg, check_hi_next;

    logic [BYTE_W-1:0]   len0, len1, len2, act_len, hit_len;
    logic                hit0, hit1, hit2;
    logic [SLOT_W-1:0]   hit_slot;
    logic [BYTE_W:0]     count_inc;

    function automatic logic [BYTE_W-1:0] sat_len(input logic [BYTE_W-1:0] len);
        return (len > MaxLen) ? MaxLen : len;
    endfunction

    assign len0 = sat_len(cfg.slot0_length);
    assign len1 = sat_len(cfg.slot1_length);
    assign len2 = sat_len(cfg.slot2_length);

    assign hit0 = (byte_in == cfg.slot0_ident);
    assign hit1 = (byte_in == cfg.slot1_ident);
    assign hit2 = (byte_in == cfg.slot2_ident);

    // lowest matching slot wins
    always_comb
    begin
        if (hit0)
        begin
            hit_slot = SLOT_0;
            hit_len  = len0;
        end
        else if (hit1)
        begin
            hit_slot = SLOT_1;
            hit_len  = len1;
        end
        else
        begin
            hit_slot = SLOT_2;
            hit_len  = len2;
        end
    end

    always_comb
    begin
        case (slot_reg)
            SLOT_0:  act_len = len0;
            SLOT_1:  act_len = len1;
            default: act_len = len2;
        endcase
    end

    assign count_inc = {1'b0, count_reg} + 9'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        slot_next     = slot_reg;
        count_next    = count_reg;
        check_hi_next = check_hi_reg;
        evt           = '0;
        evt.kind      = EV_PAYLOAD;
        case (phase_reg)
            PH_COMMAND:
            begin
                if (!(hit0 || hit1 || hit2))
                begin
                    phase_next = PH_HUNT;
                    evt.vld    = 1'b1;
                    evt.kind   = EV_UNKNOWN;
                    evt.slot   = SLOT_0;
                    evt.data   = byte_in;
                end
                else
                begin
                    slot_next  = hit_slot;
                    count_next = '0;
                    phase_next = (hit_len == '0) ? PH_CHECK_HI : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                evt.vld    = 1'b1;
                evt.kind   = EV_PAYLOAD;
                evt.slot   = slot_reg;
                evt.idx    = count_reg[INDEX_W-1:0];
                evt.data   = byte_in;
                count_next = count_inc[BYTE_W-1:0];
                if (count_inc >= {1'b0, act_len})
                begin
                    phase_next = PH_CHECK_HI;
                end
            end
            PH_CHECK_HI:
            begin
                check_hi_next = byte_in;
                phase_next    = PH_CHECK_LO;
            end
            PH_CHECK_LO:
            begin
                phase_next = PH_HUNT;
                evt.vld    = 1'b1;
                evt.kind   = ({check_hi_reg, byte_in} == cfg.expected_check) ?
                             EV_ACCEPT : EV_BADCHECK;
                evt.slot   = slot_reg;
            end
            default:
            begin
                phase_next = (byte_in == cfg.header) ? PH_COMMAND : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            slot_reg     <= '0;
            count_reg    <= '0;
            check_hi_reg <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            slot_reg     <= slot_next;
            count_reg    <= count_next;
            check_hi_reg <= check_hi_next;
        end
    end

endmodule

>>> sv/command_frame_deframer.sv
// Top level: input register, parser and result register of the command frame deframer.
// Each byte passes the input register, then the parser; a result (if any) is registered.
// Throughput: one byte per cycle unless stalled; the parser decodes a byte in one pass.
// A held result back-pressures the input register, which stalls the input only when full.
// Reset: parser hunting for a header, registers at their default values, both stages empty.
`timescale 1ns / 1ps

module command_frame_deframer #(
    parameter int MAX_PAYLOAD = cfd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [cfd_pkg::BYTE_W-1:0]      rx_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [cfd_pkg::KIND_W-1:0]      event_kind,
    output logic [cfd_pkg::SLOT_W-1:0]      command_slot,
    output logic [cfd_pkg::INDEX_W-1:0]     byte_index,
    output logic [cfd_pkg::BYTE_W-1:0]      data_byte,
    input  logic                            cfg_wr_en,
    input  logic [cfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import cfd_pkg::*;

    cfg_t               cfg;
    evt_t               evt;

    logic               s1_vld_reg, s1_vld_next;
    logic [BYTE_W-1:0]  s1_byte_reg;
    logic               out_vld_reg, out_vld_next;
    logic [KIND_W-1:0]  kind_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [BYTE_W-1:0]  data_reg;

    logic               consume;
    logic               take_in;
    logic               load_out;

    cfd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cfd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (consume),
        .byte_in (s1_byte_reg),
        .cfg     (cfg),
        .evt     (evt)
    );

    // the stored byte moves on whenever the result slot is free or draining
    assign consume  = s1_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = s1_vld_reg && !consume;
    assign take_in  = in_valid && !in_stall;
    assign load_out = consume && evt.vld;

    assign s1_vld_next  = take_in || (s1_vld_reg && !consume);
    assign out_vld_next = load_out || (out_vld_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_byte_reg <= rx_byte;
        end
        if (load_out)
        begin
            kind_reg <= evt.kind;
            slot_reg <= evt.slot;
            idx_reg  <= evt.idx;
            data_reg <= evt.data;
        end
    end

    assign out_valid    = out_vld_reg;
    assign event_kind   = kind_reg;
    assign command_slot = slot_reg;
    assign byte_index   = idx_reg;
    assign data_byte    = data_reg;

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_vld_reg && out_vld_reg))
        else $error("input stalled without a held byte and a held result");

    a_frame_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_kind != EV_PAYLOAD)) |-> (byte_index == '0))
        else $error("frame transaction carries a nonzero byte index");

    a_unknown_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_kind == EV_UNKNOWN)) |-> (command_slot == SLOT_0))
        else $error("unknown command reported with a nonzero slot");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (command_slot != 2'd3))
        else $error("result carries an undefined slot number");

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the command frame deframer: byte streams in, frame events checked.
`timescale 1ns / 1ps

module tb_top;
    import cfd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_COMMAND,
        PH_PAYLOAD,
        PH_CHECK_HI,
        PH_CHECK_LO
    } parse_phase_t;

    typedef struct {
        event_kind_t        kind;
        logic [SLOT_W-1:0]  slot;
        logic [INDEX_W-1:0] idx;
        logic [BYTE_W-1:0]  data;
    } frame_event_t;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int PAYLOAD_CAP    = MAX_PAYLOAD_DEF;
    localparam int RANDOM_ITEMS   = 400;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [BYTE_W-1:0]     rx_byte;
    logic                  out_valid;
    logic                  out_stall;
    logic [KIND_W-1:0]     event_kind;
    logic [SLOT_W-1:0]     command_slot;
    logic [INDEX_W-1:0]    byte_index;
    logic [BYTE_W-1:0]     data_byte;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // shadow registers and parser state of the deframer
    logic [BYTE_W-1:0]  m_header;
    logic [BYTE_W-1:0]  m_ident [3];
    logic [BYTE_W-1:0]  m_length [3];
    logic [CHECK_W-1:0] m_check;
    parse_phase_t       m_phase;
    logic [SLOT_W-1:0]  m_slot;
    logic [7:0]         m_count;
    logic [7:0]         m_check_hi;

    frame_event_t predicted_events[$];
    int           errors;
    int           frame_bytes_sent;
    int           idle_cycles;
    bit           quiet;

    command_frame_deframer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_kind   (event_kind),
        .command_slot (command_slot),
        .byte_index   (byte_index),
        .data_byte    (data_byte),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Deframer prediction
    // ------------------------------------------------------------------
    task automatic reset_shadow;
        m_header    = HEADER_RST;
        m_ident[0]  = SLOT0_ID_RST;
        m_length[0] = SLOT0_LEN_RST;
        m_ident[1]  = SLOT1_ID_RST;
        m_length[1] = SLOT1_LEN_RST;
        m_ident[2]  = SLOT2_ID_RST;
        m_length[2] = SLOT2_LEN_RST;
        m_check     = CHECK_RST;
        m_phase     = PH_HUNT;
        m_slot      = SLOT_0;
        m_count     = '0;
        m_check_hi  = '0;
    endtask

    function automatic int payload_limit(input logic [SLOT_W-1:0] s);
        int len;
        len = m_length[s];
        return (len > PAYLOAD_CAP) ? PAYLOAD_CAP : len;
    endfunction

    task automatic push_event(input event_kind_t k, input logic [SLOT_W-1:0] s,
                              input logic [INDEX_W-1:0] i, input logic [BYTE_W-1:0] d);
        frame_event_t ev;
        ev.kind = k;
        ev.slot = s;
        ev.idx  = i;
        ev.data = d;
        predicted_events.push_back(ev);
    endtask

    task automatic parse_byte(input logic [BYTE_W-1:0] b);
        int hit;
        int i;
        case (m_phase)
            PH_COMMAND:
            begin
                hit = 3;
                for (i = 2; i >= 0; i--)
                    if (m_ident[i] == b)
                        hit = i;
                if (hit == 3)
                begin
                    m_phase = PH_HUNT;
                    push_event(EV_UNKNOWN, SLOT_0, '0, b);
                end
                else
                begin
                    m_slot  = hit[SLOT_W-1:0];
                    m_count = '0;
                    m_phase = (payload_limit(m_slot) == 0) ? PH_CHECK_HI : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                push_event(EV_PAYLOAD, m_slot, m_count[INDEX_W-1:0], b);
                m_count = m_count + 8'd1;
                // length is looked up again on every payload byte
                if (int'(m_count) >= payload_limit(m_slot))
                    m_phase = PH_CHECK_HI;
            end
            PH_CHECK_HI:
            begin
                m_check_hi = b;
                m_phase    = PH_CHECK_LO;
            end
            PH_CHECK_LO:
            begin
                m_phase = PH_HUNT;
                push_event(({m_check_hi, b} == m_check) ? EV_ACCEPT : EV_BADCHECK,
                           m_slot, '0, '0);
            end
            default:
                m_phase = (b == m_header) ? PH_COMMAND : PH_HUNT;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        if (!(m_phase == PH_HUNT && b != m_header))
            frame_bytes_sent++;
        parse_byte(b);
    endtask

    // lets everything in flight come out, covering bytes that cause no event
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (predicted_events.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_HEADER:    m_header    = value[7:0];
            REG_SLOT0_ID:  m_ident[0]  = value[7:0];
            REG_SLOT0_LEN: m_length[0] = value[7:0];
            REG_SLOT1_ID:  m_ident[1]  = value[7:0];
            REG_SLOT1_LEN: m_length[1] = value[7:0];
            REG_SLOT2_ID:  m_ident[2]  = value[7:0];
            REG_SLOT2_LEN: m_length[2] = value[7:0];
            REG_CHECK:     m_check     = value;
            default:;
        endcase
    endtask

    // upper bits of an 8-bit register write are don't-care
    function automatic logic [CFG_DATA_W-1:0] pad_byte(input logic [7:0] v);
        logic [7:0] junk;
        junk = 8'($urandom_range(255));
        return ($urandom_range(3) == 0) ? {junk, v} : {8'h00, v};
    endfunction

    task automatic send_frame(input logic [BYTE_W-1:0] cmd, input bit good_check);
        logic [CHECK_W-1:0] word;
        send_byte(m_header);
        send_byte(cmd);
        while (m_phase == PH_PAYLOAD)
            send_byte(8'($urandom_range(255)));
        if (m_phase == PH_CHECK_HI)
        begin
            word = good_check ? m_check : CHECK_W'($urandom_range(16'hFFFF));
            send_byte(word[15:8]);
            send_byte(word[7:0]);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: back-pressure, checker, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        int r;
        int hold;
        out_stall = 1'b0;
        forever
        begin
            r    = $urandom_range(99);
            hold = $urandom_range(1, 12);
            @(negedge clk);
            if (quiet || r < 55)
                out_stall <= 1'b0;
            else if (r < 93)
            begin
                out_stall <= 1'b1;
                hold = $urandom_range(1, 3);
            end
            else
            begin
                out_stall <= 1'b1;
                hold = $urandom_range(8, 40);
            end
            repeat (hold - 1) @(negedge clk);
        end
    end

    task automatic report_mismatch(input string field, input logic [15:0] want,
                                   input logic [15:0] got);
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
    endtask

    task automatic check_event;
        frame_event_t want;
        if (predicted_events.size() == 0)
        begin
            errors++;
            $display({"%0t: unexpected event: expected none, ",
                      "actual kind %0h slot %0h index %0h data %0h"},
                     $time, event_kind, command_slot, byte_index, data_byte);
            return;
        end
        want = predicted_events.pop_front();
        if (event_kind !== want.kind)
            report_mismatch("event_kind", want.kind, event_kind);
        if (command_slot !== want.slot)
            report_mismatch("command_slot", want.slot, command_slot);
        if (byte_index !== want.idx)
            report_mismatch("byte_index", want.idx, byte_index);
        if (data_byte !== want.data)
            report_mismatch("data_byte", want.data, data_byte);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_event();
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_default_registers;
        // default header '$', slot two takes 0x55 with no payload, check 0x5555
        send_frame(SLOT2_ID_RST, 1'b1);
        send_byte(HEADER_RST);
        send_byte(SLOT2_ID_RST);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(HEADER_RST);
        send_byte(8'h07);
        drain();
    endtask

    task automatic test_default_lengths;
        send_frame(SLOT0_ID_RST, 1'b1);
        send_frame(SLOT1_ID_RST, 1'b0);
        drain();
    endtask

    task automatic test_slot_priority;
        write_reg(REG_HEADER, 16'h00FF);
        write_reg(REG_SLOT0_ID, 16'h00AA);
        write_reg(REG_SLOT0_LEN, 16'h0001);
        write_reg(REG_SLOT1_ID, 16'h00AA);
        write_reg(REG_SLOT1_LEN, 16'h0002);
        write_reg(REG_SLOT2_ID, 16'h0000);
        write_reg(REG_SLOT2_LEN, 16'h0000);
        write_reg(REG_CHECK, 16'h0000);
        // duplicate ident: slot zero must win
        send_byte(8'hFF);
        send_byte(8'hAA);
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(8'h00);
        send_frame(8'h00, 1'b0);
        // header twice: the second one is taken as an unknown command
        send_byte(8'hFF);
        send_byte(8'hFF);
        drain();
    endtask

    task automatic test_length_change_mid_frame;
        write_reg(REG_SLOT1_ID, 16'h0033);
        write_reg(REG_SLOT1_LEN, 16'h0003);
        send_byte(8'hFF);
        send_byte(8'h33);
        send_byte(8'h01);
        drain();
        // count already past the new length: payload ends after the next byte
        write_reg(REG_SLOT1_LEN, 16'h0000);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'h00);
        drain();
    endtask

    task automatic test_long_payloads;
        // 255 and 129 saturate to the cap; 128 walks the index through all 7 bits
        write_reg(REG_HEADER, 16'h0024);
        write_reg(REG_SLOT0_ID, 16'h0010);
        write_reg(REG_SLOT0_LEN, 16'h00FF);
        write_reg(REG_SLOT1_ID, 16'h0011);
        write_reg(REG_SLOT1_LEN, 16'h0080);
        write_reg(REG_SLOT2_ID, 16'h0012);
        write_reg(REG_SLOT2_LEN, 16'h0081);
        write_reg(REG_CHECK, 16'hA5C3);
        send_frame(8'h10, 1'b1);
        send_frame(8'h11, 1'b0);
        send_frame(8'h12, 1'b1);
        drain();
    endtask

    task automatic test_back_to_back;
        int n;
        quiet = 1'b1;
        write_reg(REG_HEADER, 16'hFF00);
        write_reg(REG_SLOT0_ID, 16'h00FF);
        write_reg(REG_SLOT0_LEN, 16'h0003);
        write_reg(REG_SLOT1_ID, 16'h0000);
        write_reg(REG_SLOT1_LEN, 16'h0000);
        write_reg(REG_SLOT2_ID, 16'h0080);
        write_reg(REG_SLOT2_LEN, 16'h0007);
        write_reg(REG_CHECK, 16'hFFFF);
        for (n = 0; n < 6; n++)
            send_frame(m_ident[n % 3], n[0]);
        drain();
        quiet = 1'b0;
    endtask

    task automatic randomize_registers;
        logic [7:0]  v;
        int          r;
        int          s;
        r = $urandom_range(99);
        v = (r < 10) ? 8'h00 : (r < 20) ? 8'hFF : 8'($urandom_range(255));
        write_reg(REG_HEADER, pad_byte(v));
        for (s = 0; s < 3; s++)
        begin
            r = $urandom_range(99);
            if (r < 20 && s > 0)
                v = m_ident[$urandom_range(s - 1)];
            else if (r < 30)
                v = r[0] ? 8'hFF : 8'h00;
            else
                v = 8'($urandom_range(255));
            write_reg(cfg_idx_t'(REG_SLOT0_ID + 2 * s), pad_byte(v));
            r = $urandom_range(99);
            if (r < 10)
                v = 8'd0;
            else if (r < 80)
                v = 8'($urandom_range(1, 6));
            else if (r < 92)
                v = 8'($urandom_range(7, 20));
            else
                case ($urandom_range(3))
                    0: v = 8'd127;
                    1: v = 8'd128;
                    2: v = 8'd129;
                    default: v = 8'd255;
                endcase
            write_reg(cfg_idx_t'(REG_SLOT0_LEN + 2 * s), pad_byte(v));
        end
        r = $urandom_range(99);
        write_reg(REG_CHECK, (r < 10) ? 16'h0000 : (r < 20) ? 16'hFFFF
                             : CHECK_W'($urandom_range(16'hFFFF)));
    endtask

    task automatic test_random_frames;
        int target;
        int frames;
        int r;
        int n;
        target = frame_bytes_sent + RANDOM_ITEMS;
        frames = 0;
        while (frame_bytes_sent < target)
        begin
            if (frames % 12 == 0)
            begin
                drain();
                randomize_registers();
            end
            frames++;
            r = $urandom_range(99);
            if (r < 75)
                send_frame(($urandom_range(99) < 85) ? m_ident[$urandom_range(2)]
                                                     : 8'($urandom_range(255)),
                           $urandom_range(99) < 70);
            else if (r < 86)
            begin
                // line noise, now and then a stray header
                for (n = $urandom_range(1, 4); n > 0; n--)
                    send_byte(($urandom_range(5) == 0) ? m_header : 8'($urandom_range(255)));
            end
            else if (r < 94)
            begin
                send_byte(m_header);
                send_byte(8'($urandom_range(255)));
            end
            else
                drain();
        end
        drain();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        rx_byte          = '0;
        cfg_wr_en        = 1'b0;
        cfg_index        = REG_HEADER;
        cfg_data         = '0;
        quiet            = 1'b0;
        errors           = 0;
        frame_bytes_sent = 0;
        idle_cycles      = 0;
        reset_shadow();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_registers();
        test_default_lengths();
        test_slot_priority();
        test_length_change_mid_frame();
        test_long_payloads();
        test_back_to_back();
        test_random_frames();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
